// ===== hdl/gbws_pkg.sv =====
// Shared types, constants and operation codes for the growable bit set word store.
package gbws_pkg;

	// Fixed widths of the item fields.
	localparam int OP_W      = 3;
	localparam int IDX_W     = 10;
	localparam int SEL_W     = 5;
	localparam int VALUE_W   = 32;
	localparam int COUNT_O_W = 6;

	// Default build sizes.
	localparam int NUM_WORDS_DEF = 32;
	localparam int WORD_BITS_DEF = 32;

	// Fraction bits of the reciprocal used to split a bit index into word and bit.
	localparam int DIV_SHIFT = 24;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TEST       = 3'd0;
	localparam logic [OP_W-1:0] OP_SET        = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_WORD  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_COUNT = 3'd4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SHR_RD,
		ST_SHR_CHK,
		ST_RESP
	} gbws_state_t;

	// Control flags from the sequencer to the datapath.
	typedef struct packed {
		logic clearing;
		logic idle;
		logic rmw;
		logic shr_rd;
		logic shr_chk;
		logic resp;
	} gbws_ctl_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic shrink_go;
		logic shrink_more;
		logic out_free;
	} gbws_stat_t;

endpackage

// ===== hdl/growable_bitset_word_store_unit.sv =====
// Top level of the growable bit set word store: item datapath, word memory and sequencer.
//
// A bit set held in NUM_WORDS words of WORD_BITS bits, with a count of words in use.
// After reset the block zeroes the word memory, one word a cycle, and holds in_stall
// high meanwhile. For each item the word is then read from the memory in the idle
// state, and is modified, written back and turned into the result in the next state.
// A clear that leaves the top word empty walks down the memory, reading and then
// checking one word at a time, while further words are zero.
// The result sits in an output register, and the next item is taken while
// that result waits; a second result waits only if the first has not yet been taken.
module growable_bitset_word_store_unit #(
	parameter int NUM_WORDS = gbws_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = gbws_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gbws_pkg::OP_W-1:0]         operation,
	input  logic [gbws_pkg::IDX_W-1:0]        bit_index,
	input  logic [gbws_pkg::SEL_W-1:0]        word_select,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              bit_value,
	output logic [gbws_pkg::VALUE_W-1:0]      word_value,
	output logic [gbws_pkg::COUNT_O_W-1:0]    words_in_use
);

	localparam int IDX_W  = gbws_pkg::IDX_W;
	localparam int SEL_W  = gbws_pkg::SEL_W;
	localparam int AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW     = $clog2(NUM_WORDS + 1);
	localparam int WN_W   = $clog2((2 ** IDX_W - 1) / WORD_BITS + 1);
	localparam int BN_W   = $clog2(WORD_BITS);
	localparam int MX1    = (CW > WN_W) ? CW : WN_W;
	localparam int CMP_W  = ((MX1 > SEL_W) ? MX1 : SEL_W) + 1;
	localparam int RECIP  = (2 ** gbws_pkg::DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W = IDX_W + gbws_pkg::DIV_SHIFT;
	localparam int OW     = (WORD_BITS > gbws_pkg::VALUE_W) ? WORD_BITS : gbws_pkg::VALUE_W;
	localparam int CO_W   = (CW > gbws_pkg::COUNT_O_W) ? CW : gbws_pkg::COUNT_O_W;

	gbws_pkg::gbws_ctl_t  ctl;
	gbws_pkg::gbws_stat_t stat;
	logic [AW-1:0]        clr_addr;

	// Item registers.
	logic [gbws_pkg::OP_W-1:0] op_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [SEL_W-1:0]          sel_s1;
	logic [WN_W-1:0]           wnum_s1;

	// Word count and held result.
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic                         res_bit_q;
	logic [gbws_pkg::VALUE_W-1:0] res_word_q;

	// Output register.
	logic                           out_valid_q;
	logic                           bit_value_q;
	logic [gbws_pkg::VALUE_W-1:0]   word_value_q;
	logic [gbws_pkg::COUNT_O_W-1:0] words_in_use_q;

	// Memory ports.
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// Index split and comparisons.
	logic [PROD_W-1:0]    quot_prod;
	logic [WN_W-1:0]      in_wnum;
	logic [CMP_W-1:0]     in_wnum_x;
	logic [CMP_W-1:0]     in_sel_x;
	logic [IDX_W-1:0]     rem_full;
	logic [BN_W-1:0]      bnum;
	logic [WORD_BITS-1:0] bmask;
	logic [CMP_W-1:0]     wnum_x;
	logic [CMP_W-1:0]     sel_x;
	logic [CMP_W-1:0]     cnt_x;
	logic [CMP_W-1:0]     cap_x;
	logic [CW-1:0]        cnt_m1;
	logic [CMP_W-1:0]     cnt_m1_x;
	logic                 wnum_ok;
	logic                 wnum_live;
	logic                 sel_live;
	logic                 wnum_top;

	// Result assembly.
	logic                         rmw_bit;
	logic [WORD_BITS-1:0]         rmw_word;
	logic [OW-1:0]                rmw_word_wide;
	logic [CO_W-1:0]              cnt_wide;
	logic                         out_load;

	gbws_ctrl #(
		.NUM_WORDS (NUM_WORDS),
		.AW        (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl),
		.clr_addr (clr_addr)
	);

	gbws_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall  = !ctl.idle;
	assign out_valid = out_valid_q;
	assign bit_value    = bit_value_q;
	assign word_value   = word_value_q;
	assign words_in_use = words_in_use_q;

	// Word number of the incoming bit index by reciprocal multiplication.
	assign quot_prod = PROD_W'(bit_index) * PROD_W'(RECIP);
	assign in_wnum   = quot_prod[gbws_pkg::DIV_SHIFT +: WN_W];
	assign in_wnum_x = CMP_W'(in_wnum);
	assign in_sel_x  = CMP_W'(word_select);

	// Bit number and mask of the registered item.
	assign rem_full = idx_s1 - IDX_W'(IDX_W'(wnum_s1) * IDX_W'(WORD_BITS));
	assign bnum     = rem_full[BN_W-1:0];
	assign bmask    = WORD_BITS'(1) << bnum;

	// Range checks against the capacity and the count before this item.
	assign wnum_x    = CMP_W'(wnum_s1);
	assign sel_x     = CMP_W'(sel_s1);
	assign cnt_x     = CMP_W'(count_q);
	assign cap_x     = CMP_W'(NUM_WORDS);
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m1_x  = CMP_W'(cnt_m1);
	assign wnum_ok   = (wnum_x < cap_x);
	assign wnum_live = wnum_ok && (wnum_x < cnt_x);
	assign sel_live  = (sel_x < cap_x) && (sel_x < cnt_x);
	assign wnum_top  = ((wnum_x + CMP_W'(1)) == cnt_x);

	// Memory read address: the item's word on acceptance, the next word down while shrinking.
	always_comb begin
		if (ctl.shr_rd) begin
			mem_raddr = cnt_m1_x[AW-1:0];
		end else if (operation == gbws_pkg::OP_READ_WORD) begin
			mem_raddr = in_sel_x[AW-1:0];
		end else begin
			mem_raddr = in_wnum_x[AW-1:0];
		end
	end

	// Read-modify-write, count update and shrink decisions.
	always_comb begin
		mem_we           = 1'b0;
		mem_waddr        = wnum_x[AW-1:0];
		mem_wdata        = mem_rdata;
		count_d          = count_q;
		rmw_bit          = 1'b0;
		rmw_word         = '0;
		stat.out_free    = !out_valid_q || !out_stall;
		stat.shrink_go   = 1'b0;
		stat.shrink_more = 1'b0;
		if (ctl.clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr;
			mem_wdata = '0;
		end else if (ctl.rmw) begin
			unique case (op_s1)
				gbws_pkg::OP_TEST: begin
					rmw_bit = wnum_live && mem_rdata[bnum];
				end
				gbws_pkg::OP_SET: begin
					if (wnum_ok) begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata | bmask;
						if (!(wnum_x < cnt_x)) begin
							count_d = CW'(wnum_x + CMP_W'(1));
						end
					end
				end
				gbws_pkg::OP_CLEAR: begin
					if (wnum_live) begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata & ~bmask;
						if (wnum_top && (mem_wdata == '0) && (cnt_x > CMP_W'(1))) begin
							count_d        = cnt_m1;
							stat.shrink_go = (cnt_x > CMP_W'(2));
						end
					end
				end
				gbws_pkg::OP_READ_WORD: begin
					if (sel_live) begin
						rmw_word = mem_rdata;
					end
				end
				default: begin
					rmw_bit = 1'b0;
				end
			endcase
		end else if (ctl.shr_chk) begin
			if (mem_rdata == '0) begin
				count_d          = cnt_m1;
				stat.shrink_more = (cnt_x > CMP_W'(2));
			end
		end
	end

	// Output load conditions and width mapping of the result.
	assign out_load = stat.out_free &&
		((ctl.rmw && !stat.shrink_go) || (ctl.shr_chk && !stat.shrink_more) || ctl.resp);
	assign rmw_word_wide = OW'(rmw_word);
	assign cnt_wide      = CO_W'(count_d);

	// Item capture on acceptance, held result and output register.
	always_ff @(posedge clk) begin
		if (ctl.idle && in_valid) begin
			op_s1   <= operation;
			idx_s1  <= bit_index;
			sel_s1  <= word_select;
			wnum_s1 <= in_wnum;
		end
		if (ctl.rmw) begin
			res_bit_q  <= rmw_bit;
			res_word_q <= rmw_word_wide[gbws_pkg::VALUE_W-1:0];
		end
		if (out_load) begin
			bit_value_q    <= ctl.rmw ? rmw_bit : res_bit_q;
			word_value_q   <= ctl.rmw ? rmw_word_wide[gbws_pkg::VALUE_W-1:0] : res_word_q;
			words_in_use_q <= cnt_wide[gbws_pkg::COUNT_O_W-1:0];
		end
	end

	// Count of words in use and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/gbws_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module gbws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/gbws_ctrl.sv =====
// Sequencer for the word store: clearing pass, read-modify-write and shrink walk.
module gbws_ctrl #(
	parameter int NUM_WORDS = gbws_pkg::NUM_WORDS_DEF,
	parameter int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  gbws_pkg::gbws_stat_t stat,
	output gbws_pkg::gbws_ctl_t  ctl,
	output logic [AW-1:0]       clr_addr
);

	gbws_pkg::gbws_state_t st_q;
	gbws_pkg::gbws_state_t st_d;
	logic [AW-1:0]         clr_q;
	logic                  clr_last;

	assign clr_last = (clr_q == AW'(NUM_WORDS - 1));
	assign clr_addr = clr_q;

	// State register and clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= gbws_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == gbws_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			gbws_pkg::ST_CLEAR: begin
				if (clr_last) st_d = gbws_pkg::ST_IDLE;
			end
			gbws_pkg::ST_IDLE: begin
				if (in_valid) st_d = gbws_pkg::ST_RMW;
			end
			gbws_pkg::ST_RMW: begin
				if (stat.shrink_go) st_d = gbws_pkg::ST_SHR_RD;
				else if (stat.out_free) st_d = gbws_pkg::ST_IDLE;
				else st_d = gbws_pkg::ST_RESP;
			end
			gbws_pkg::ST_SHR_RD: begin
				st_d = gbws_pkg::ST_SHR_CHK;
			end
			gbws_pkg::ST_SHR_CHK: begin
				if (stat.shrink_more) st_d = gbws_pkg::ST_SHR_RD;
				else if (stat.out_free) st_d = gbws_pkg::ST_IDLE;
				else st_d = gbws_pkg::ST_RESP;
			end
			gbws_pkg::ST_RESP: begin
				if (stat.out_free) st_d = gbws_pkg::ST_IDLE;
			end
			default: st_d = gbws_pkg::ST_CLEAR;
		endcase
	end

	// Control flags decoded from the state.
	always_comb begin
		ctl = '0;
		unique case (st_q)
			gbws_pkg::ST_CLEAR:   ctl.clearing = 1'b1;
			gbws_pkg::ST_IDLE:    ctl.idle     = 1'b1;
			gbws_pkg::ST_RMW:     ctl.rmw      = 1'b1;
			gbws_pkg::ST_SHR_RD:  ctl.shr_rd   = 1'b1;
			gbws_pkg::ST_SHR_CHK: ctl.shr_chk  = 1'b1;
			gbws_pkg::ST_RESP:    ctl.resp     = 1'b1;
			default:              ctl          = '0;
		endcase
	end

endmodule
